// File: hw/rtl/assert_macros.svh
// assertion helpers, expect clk and rst_n in the calling scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/spfl_pkg.sv
// ----------------------------------------------------------------------------
// spfl_pkg
// Types and constants of the slot pool free list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spfl_pkg;

  localparam int SLOTS = 4096;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;

  localparam logic [CNT_W-1:0] EMPTY = CNT_W'(SLOTS);

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_FREE_ALL = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BEYOND   = 2'd1;
  localparam logic [1:0] STAT_INACTIVE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_VICT_RD,
    S_FREE_RD,
    S_WALK,
    S_RESP
  } state_t;

  // one word per slot: active flag and free-list link
  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] link;
  } entry_t;

endpackage

// File: hw/rtl/slot_pool_free_list_allocator.sv
// ----------------------------------------------------------------------------
// slot_pool_free_list_allocator
// Slot pool handed out through a linked free list kept in one memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one request: allocate, free one
// slot or free all. Each request gives exactly one result on the output
// channel (out_valid / out_stall), held in an output register.
// Computed in the accepting cycle: allocate at the high-water mark, free
// beyond the mark, unused code. Computed after one slot memory read:
// allocate from the free-list head, allocate into a full pool, free. Free-all
// walks the slots below the high-water mark, one slot per cycle through the
// memory. The slot memory has a separate write port, and its read is
// registered: the read data returns in the cycle after the address.
// A new request is accepted in the
// cycle after the previous result has been placed in the output register;
// if the output register is still full and stalled, the result waits in a
// holding register and input stays stalled until it moves on.
// Reset clears the control state: free list empty, mark and count zero.
// The slot memory needs no clearing: every slot below the high-water mark
// has been written, and slots above it are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module slot_pool_free_list_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [spfl_pkg::IDX_W-1:0] in_slot_index,
  input  logic [spfl_pkg::IDX_W-1:0] in_victim_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [spfl_pkg::IDX_W-1:0] out_granted_slot,
  output logic                      out_evicted,
  output logic [1:0]                out_status,
  output logic [spfl_pkg::CNT_W-1:0] out_active_count
);

  import spfl_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] hw_r, hw_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] walk_r, walk_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] paddr_r, paddr_nxt;

  // slot memory
  entry_t           mem [SLOTS];
  entry_t           rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic [IDX_W-1:0] mem_ra;

  // result of the finishing cycle
  logic             res_done;
  logic [IDX_W-1:0] res_g;
  logic             res_ev;
  logic [1:0]       res_st;

  // holding register for a result that meets a stalled output
  logic [IDX_W-1:0] hold_g_r;
  logic             hold_ev_r;
  logic [1:0]       hold_st_r;
  logic [CNT_W-1:0] hold_cnt_r;
  logic             hold_ld;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_g_r;
  logic             out_ev_r;
  logic [1:0]       out_st_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_free;
  logic             out_ld;
  logic [IDX_W-1:0] ld_g;
  logic             ld_ev;
  logic [1:0]       ld_st;
  logic [CNT_W-1:0] ld_cnt;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_g_r;
  assign out_evicted      = out_ev_r;
  assign out_status       = out_st_r;
  assign out_active_count = out_cnt_r;
  assign out_free         = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    hw_nxt    = hw_r;
    live_nxt  = live_r;
    slot_nxt  = slot_r;
    walk_nxt  = walk_r;
    pend_nxt  = pend_r;
    paddr_nxt = paddr_r;
    mem_we    = 1'b0;
    mem_wa    = slot_r;
    mem_wd    = '0;
    mem_ra    = slot_r;
    res_done  = 1'b0;
    res_g     = '0;
    res_ev    = 1'b0;
    res_st    = STAT_OK;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            OP_ALLOC: begin
              if (head_r < EMPTY) begin
                mem_ra    = head_r[IDX_W-1:0];
                slot_nxt  = head_r[IDX_W-1:0];
                state_nxt = S_ALLOC_RD;
              end else if (hw_r < EMPTY) begin
                // never-used slot, nothing to read
                res_done    = 1'b1;
                res_g       = hw_r[IDX_W-1:0];
                mem_we      = 1'b1;
                mem_wa      = hw_r[IDX_W-1:0];
                mem_wd      = '{active: 1'b1, link: '0};
                hw_nxt      = hw_r + 1'b1;
                live_nxt    = live_r + 1'b1;
              end else begin
                mem_ra    = in_victim_index;
                slot_nxt  = in_victim_index;
                state_nxt = S_VICT_RD;
              end
            end
            OP_FREE: begin
              if ({1'b0, in_slot_index} >= hw_r) begin
                res_done = 1'b1;
                res_st   = STAT_BEYOND;
              end else begin
                mem_ra    = in_slot_index;
                slot_nxt  = in_slot_index;
                state_nxt = S_FREE_RD;
              end
            end
            OP_FREE_ALL: begin
              walk_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_WALK;
            end
            default: begin
              res_done = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        res_done = 1'b1;
        res_g    = slot_r;
        head_nxt = (rdata_r.link > EMPTY) ? EMPTY : rdata_r.link;
        mem_we   = 1'b1;
        mem_wd   = '{active: 1'b1, link: '0};
        live_nxt = live_r + 1'b1;
      end
      S_VICT_RD: begin
        res_done = 1'b1;
        res_g    = slot_r;
        if (rdata_r.active) begin
          res_ev = 1'b1;
        end else begin
          mem_we   = 1'b1;
          mem_wd   = '{active: 1'b1, link: '0};
          live_nxt = live_r + 1'b1;
        end
      end
      S_FREE_RD: begin
        res_done = 1'b1;
        if (!rdata_r.active) begin
          res_st = STAT_INACTIVE;
        end else begin
          mem_we   = 1'b1;
          mem_wd   = '{active: 1'b0, link: head_r};
          head_nxt = {1'b0, slot_r};
          live_nxt = live_r - 1'b1;
        end
      end
      S_WALK: begin
        // read slot walk_r while the slot read last cycle is pushed
        if (walk_r < hw_r) begin
          mem_ra    = walk_r[IDX_W-1:0];
          walk_nxt  = walk_r + 1'b1;
          pend_nxt  = 1'b1;
          paddr_nxt = walk_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && rdata_r.active) begin
          mem_we   = 1'b1;
          mem_wa   = paddr_r;
          mem_wd   = '{active: 1'b0, link: head_r};
          head_nxt = {1'b0, paddr_r};
          live_nxt = live_r - 1'b1;
        end
        if (!pend_r && walk_r >= hw_r) begin
          res_done = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // route the finished result to the output or the holding register
    hold_ld = 1'b0;
    out_ld  = 1'b0;
    ld_g    = res_g;
    ld_ev   = res_ev;
    ld_st   = res_st;
    ld_cnt  = live_nxt;
    if (state_r == S_RESP) begin
      out_ld = out_free;
      ld_g   = hold_g_r;
      ld_ev  = hold_ev_r;
      ld_st  = hold_st_r;
      ld_cnt = hold_cnt_r;
    end else if (res_done) begin
      if (out_free) begin
        out_ld    = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        hold_ld   = 1'b1;
        state_nxt = S_RESP;
      end
    end

    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= EMPTY;
      hw_r        <= '0;
      live_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      hw_r        <= hw_nxt;
      live_r      <= live_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    walk_r  <= walk_nxt;
    paddr_r <= paddr_nxt;
    if (hold_ld) begin
      hold_g_r   <= res_g;
      hold_ev_r  <= res_ev;
      hold_st_r  <= res_st;
      hold_cnt_r <= live_nxt;
    end
    if (out_ld) begin
      out_g_r   <= ld_g;
      out_ev_r  <= ld_ev;
      out_st_r  <= ld_st;
      out_cnt_r <= ld_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  `ASSERT_HOLDS(a_live_below_mark, live_r <= hw_r)
  `ASSERT_HOLDS(a_head_below_mark, head_r == EMPTY || head_r < hw_r)
  `ASSERT_NEXT(a_free_all_clears, state_r == S_WALK && state_nxt != S_WALK, live_r == '0)

endmodule

// File: tb/slot_pool_free_list_allocator_tb.sv
// ----------------------------------------------------------------------------
// slot_pool_free_list_allocator_tb
// Self-checking bench for the slot pool allocator. A shadow copy of the pool
// (free-list links, active flags, head, high-water mark, count) predicts each
// result at input acceptance; results are compared field by field in order.
// Stimulus: a directed opening, mixed random traffic on a small pool,
// allocate-heavy traffic that raises the mark, a free-all, then mixed frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_pool_free_list_allocator_tb;
  import spfl_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT = 20000;
  localparam int         TAIL_CYCLES = 20;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] victim;
  } pool_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             evicted;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } pool_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_operation;
  logic [IDX_W-1:0] in_slot_index;
  logic [IDX_W-1:0] in_victim_index;
  logic             out_valid;
  logic             out_stall;
  logic [IDX_W-1:0] out_granted_slot;
  logic             out_evicted;
  logic [1:0]       out_status;
  logic [CNT_W-1:0] out_active_count;

  // shadow pool state
  logic [CNT_W-1:0] slot_link [SLOTS];
  logic             slot_live [SLOTS];
  logic [CNT_W-1:0] free_head;
  logic [CNT_W-1:0] mark;
  logic [CNT_W-1:0] live_total;

  pool_req_t    req_backlog [$];
  pool_result_t due_results [$];

  bit in_taken;
  bit out_taken;
  bit calm;
  int in_gap;
  int out_hold;
  int quiet;
  int errors;
  int issued;
  int checked;
  int evictions;
  int wipes;

  slot_pool_free_list_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_slot_index    (in_slot_index),
    .in_victim_index  (in_victim_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_evicted      (out_evicted),
    .out_status       (out_status),
    .out_active_count (out_active_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void release_slot(input logic [IDX_W-1:0] s);
    slot_link[s] = free_head;
    free_head    = {1'b0, s};
    slot_live[s] = 1'b0;
    live_total   = live_total - 1'b1;
  endfunction

  function automatic pool_result_t apply_request(input pool_req_t r);
    pool_result_t res;
    res = '0;
    res.status = STAT_OK;
    case (r.op)
      OP_ALLOC: begin
        if (free_head < EMPTY) begin
          res.slot  = free_head[IDX_W-1:0];
          free_head = slot_link[res.slot];
          if (free_head > EMPTY) free_head = EMPTY;
          slot_live[res.slot] = 1'b1;
          live_total = live_total + 1'b1;
        end else if (mark < EMPTY) begin
          res.slot = mark[IDX_W-1:0];
          mark = mark + 1'b1;
          slot_live[res.slot] = 1'b1;
          live_total = live_total + 1'b1;
        end else begin
          // full pool: victim index is already within range at 12 bits
          res.slot = r.victim;
          if (slot_live[r.victim]) begin
            res.evicted = 1'b1;
          end else begin
            slot_live[r.victim] = 1'b1;
            live_total = live_total + 1'b1;
          end
        end
      end
      OP_FREE: begin
        if ({1'b0, r.slot} >= mark) begin
          res.status = STAT_BEYOND;
        end else if (!slot_live[r.slot]) begin
          res.status = STAT_INACTIVE;
        end else begin
          release_slot(r.slot);
        end
      end
      OP_FREE_ALL: begin
        // ascending walk leaves the highest active slot at the head
        for (int i = 0; i < SLOTS; i++) begin
          if (i < mark && slot_live[i]) release_slot(IDX_W'(i));
        end
      end
      default: begin
      end
    endcase
    res.count = live_total;
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] pick_free_target();
    int unsigned roll;
    int unsigned top;
    logic [IDX_W-1:0] s;
    roll = $urandom_range(0, 9);
    top  = mark;
    s    = IDX_W'($urandom);
    if (top == 0 || roll == 0) return s;
    if (roll <= 2) return IDX_W'($urandom_range(0, (top + 3 > SLOTS - 1) ? SLOTS - 1 : top + 3));
    for (int t = 0; t < 8; t++) begin
      s = IDX_W'($urandom_range(0, top - 1));
      if (slot_live[s]) break;
    end
    return s;
  endfunction

  function automatic void push_req(input logic [1:0] op, input logic [IDX_W-1:0] slot,
                                   input logic [IDX_W-1:0] victim);
    pool_req_t r;
    r.op     = op;
    r.slot   = slot;
    r.victim = victim;
    req_backlog.push_back(r);
    issued++;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // wait until every queued request has been taken by the block
  task automatic drain_backlog();
    while (req_backlog.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic queue_burst(input int n, input int alloc_pct, input int free_pct,
                             input int wipe_pct);
    int roll;
    logic [1:0] op;
    calm = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) op = OP_ALLOC;
      else if (roll < alloc_pct + free_pct) op = OP_FREE;
      else if (roll < alloc_pct + free_pct + wipe_pct) op = OP_FREE_ALL;
      else op = OP_UNUSED;
      push_req(op, (op == OP_FREE) ? pick_free_target() : IDX_W'($urandom), IDX_W'($urandom));
    end
    drain_backlog();
  endtask

  // request driver
  always @(negedge clk) begin
    pool_req_t nxt;
    logic drive;
    if (rst_n) begin
      drive = in_valid && !in_taken;
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap   = calm ? 0 : $urandom_range(0, 9);
      end
      if (!drive) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (req_backlog.size() != 0) begin
          nxt = req_backlog.pop_front();
          drive = 1'b1;
          in_operation    <= nxt.op;
          in_slot_index   <= nxt.slot;
          in_victim_index <= nxt.victim;
        end
      end
      in_valid <= drive;
    end
  end

  // result side back-pressure, counted in cycles of valid output
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_hold  = calm ? 0 : $urandom_range(0, 9);
      end
      out_stall <= (out_hold > 0);
      if (out_hold > 0 && out_valid) out_hold--;
    end
  end

  // monitor: checks results, predicts on accepted requests, watchdog
  always @(posedge clk) begin
    pool_req_t    req;
    pool_result_t want;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved     = 1'b1;
        out_taken = 1'b1;
        checked++;
        if (out_evicted === 1'b1) evictions++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (slot %0d count %0d)",
                                    out_granted_slot, out_active_count));
        end else begin
          want = due_results.pop_front();
          if (out_granted_slot !== want.slot)
            report_mismatch($sformatf("granted_slot got %0d want %0d",
                                      out_granted_slot, want.slot));
          if (out_evicted !== want.evicted)
            report_mismatch($sformatf("evicted got %0d want %0d", out_evicted, want.evicted));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_active_count !== want.count)
            report_mismatch($sformatf("active_count got %0d want %0d",
                                      out_active_count, want.count));
        end
      end
      if (in_valid && !in_stall) begin
        moved    = 1'b1;
        in_taken = 1'b1;
        req.op     = in_operation;
        req.slot   = in_slot_index;
        req.victim = in_victim_index;
        if (req.op == OP_FREE_ALL) wipes++;
        due_results.push_back(apply_request(req));
      end
      if (moved) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                   quiet, due_results.size());
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_ALLOC;
    in_slot_index   = '0;
    in_victim_index = '0;
    out_stall       = 1'b0;
    free_head       = EMPTY;
    mark            = '0;
    live_total      = '0;
    for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening on an empty pool
    push_req(OP_FREE, '0, '0);
    push_req(OP_FREE, '1, '1);
    push_req(OP_FREE_ALL, '0, '0);
    push_req(OP_UNUSED, '1, '1);
    push_req(OP_UNUSED, '0, '0);
    push_req(OP_ALLOC, '0, '1);
    push_req(OP_ALLOC, '1, '0);
    push_req(OP_ALLOC, '0, '0);
    push_req(OP_FREE, 12'd1, '0);
    push_req(OP_FREE, 12'd1, '0);   // second free of the same slot
    push_req(OP_FREE, '1, '0);
    push_req(OP_ALLOC, '0, '0);     // comes back from the list head
    push_req(OP_FREE, 12'd0, '0);
    push_req(OP_FREE, 12'd2, '0);
    push_req(OP_ALLOC, '0, '0);
    push_req(OP_ALLOC, '0, '0);     // follows the link written by the push
    push_req(OP_ALLOC, '0, '1);     // list empty again, takes the mark
    push_req(OP_FREE_ALL, '1, '1);
    push_req(OP_ALLOC, '0, '0);
    push_req(OP_FREE, 12'd3, '1);
    drain_backlog();

    // mixed traffic while the pool stays small
    while (issued < 470) queue_burst($urandom_range(1, 16), 52, 40, 3);

    // allocate-heavy traffic raises the high-water mark
    while (issued < 690) queue_burst($urandom_range(4, 16), 80, 18, 0);
    push_req(OP_FREE_ALL, IDX_W'($urandom), IDX_W'($urandom));
    drain_backlog();

    // frees and allocations around the refilled free list
    while (issued < 850) queue_burst($urandom_range(1, 16), 45, 50, 2);

    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d checked results, %0d of them free-all",
             issued, checked, wipes);
    $display("high-water mark reached %0d, %0d evictions seen, %0d mismatches",
             mark, evictions, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
